// ===== rtl/core/efpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpt_pkg: shared definitions of the encoder frame position tracker
// Frame layout, wrap constants, the frame record type and register map.
// ----------------------------------------------------------------------------
package efpt_pkg;

  // Frame layout: sync byte, status byte, 24-bit little-endian position,
  // XOR check byte.
  localparam int FRAME_BYTES = 6;
  localparam int IDX_W       = 3;
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_POS0  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_POS1  = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_POS2  = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(FRAME_BYTES - 1);

  localparam logic [7:0] SYNC_RESET = 8'h32;

  // Wrap correction: step = d - trunc(d / WRAP_HALF) * WRAP_SPAN.
  localparam int WRAP_HALF = 2560000;
  localparam int WRAP_SPAN = 5120000 - 1;
  localparam int QMAX      = 6;     // largest |trunc(d / WRAP_HALF)|

  localparam int Q_DEPTH = 2;

  // APB register map, one 32-bit register per word.
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_BYTE = REG_IDX_W'(0);

  typedef struct packed {
    logic        ok;
    logic [23:0] pos;
  } frame_t;

  // Correction magnitude for a quotient magnitude k.
  function automatic logic [25:0] wrap_corr(input logic [2:0] k);
    logic [25:0] r;
    r = 26'(k) * 26'(WRAP_SPAN);
    return r;
  endfunction

endpackage

// ===== rtl/core/efpt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpt_if: valid/ready channels of the encoder frame position tracker
// Byte input channel and frame result channel.
// ----------------------------------------------------------------------------
interface efpt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efpt_result_if;
  logic               valid;
  logic               ready;
  logic               check_ok;
  logic        [23:0] raw_position;
  logic signed [24:0] position_step;
  logic signed [31:0] total_position;
  logic        [15:0] check_error_count;

  modport source (output valid, output check_ok, output raw_position,
                  output position_step, output total_position,
                  output check_error_count, input ready);
  modport sink   (input valid, input check_ok, input raw_position,
                  input position_step, input total_position,
                  input check_error_count, output ready);
endinterface

// ===== rtl/core/efpt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpt_front: sync hunt and frame assembly
// Locks on the sync byte, counts bytes and emits one frame record per frame.
// ----------------------------------------------------------------------------
module efpt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic      [7:0] sync_byte,
  input  logic            in_valid,
  input  logic      [7:0] in_byte,
  output logic            in_ready,
  output logic            push,
  output efpt_pkg::frame_t push_data,
  input  logic            q_full
);
  import efpt_pkg::*;

  logic             locked;
  logic [IDX_W-1:0] idx;
  logic [7:0]       xacc;
  logic [23:0]      pos;
  logic             take;

  // Only the last byte of a frame needs room in the queue.
  assign in_ready = !(locked && (idx == IDX_CHECK) && q_full);
  assign take     = in_valid && in_ready;
  assign push     = take && locked && (idx == IDX_CHECK);

  assign push_data.ok  = (xacc == in_byte);
  assign push_data.pos = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      locked <= 1'b0;
      idx    <= IDX_FIRST;
    end else if (take) begin
      if (!locked) begin
        if (in_byte == sync_byte) begin
          locked <= 1'b1;
          idx    <= IDX_W'(1);
        end
      end else if (idx == IDX_CHECK) begin
        idx <= IDX_FIRST;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!locked || (idx == IDX_FIRST)) begin
        xacc <= in_byte;
      end else begin
        xacc <= xacc ^ in_byte;
      end
      if (locked) begin
        case (idx)
          IDX_POS0: pos[7:0]   <= in_byte;
          IDX_POS1: pos[15:8]  <= in_byte;
          IDX_POS2: pos[23:16] <= in_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/efpt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpt_queue: frame record queue
// Small FIFO that decouples frame assembly from the position arithmetic.
// ----------------------------------------------------------------------------
module efpt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  efpt_pkg::frame_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output efpt_pkg::frame_t pop_data
);
  import efpt_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  frame_t           slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(Q_DEPTH));
  assign not_empty = (count != CNT_W'(0));
  assign pop_data  = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(Q_DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (do_pop) rd_ptr <= bump(rd_ptr);
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/core/efpt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpt_back: position difference, wrap correction and accumulation
// Three-stage pipeline from a frame record to the result register.
// ----------------------------------------------------------------------------
module efpt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  efpt_pkg::frame_t  q_data,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              res_ok,
  output logic       [23:0] res_raw,
  output logic signed [24:0] res_step,
  output logic signed [31:0] res_total,
  output logic       [15:0] res_err
);
  import efpt_pkg::*;

  logic               advance;
  logic [23:0]        prev_pos;

  logic               s1_valid;
  logic               s1_ok;
  logic [23:0]        s1_pos;
  logic signed [24:0] s1_d;

  logic               s2_valid;
  logic               s2_ok;
  logic [23:0]        s2_pos;
  logic signed [24:0] s2_step;

  logic signed [24:0] d_new;
  logic signed [25:0] d_ext;
  logic [QMAX-1:0]    ge_pos;
  logic [QMAX-1:0]    le_neg;
  logic [2:0]         qmag;
  logic [25:0]        corr;
  logic signed [25:0] step_wide;

  assign advance = !res_valid || res_ready;
  assign q_pop   = advance && q_valid;
  assign d_new   = $signed({1'b0, q_data.pos}) - $signed({1'b0, prev_pos});

  // Quotient magnitude from a row of threshold compares.
  always_comb begin
    d_ext = 26'(s1_d);
    qmag  = 3'd0;
    for (int k = 1; k <= QMAX; k++) begin
      ge_pos[k-1] = d_ext >= $signed(26'(k * WRAP_HALF));
      le_neg[k-1] = d_ext <= -$signed(26'(k * WRAP_HALF));
    end
    for (int k = 0; k < QMAX; k++) begin
      qmag = qmag + 3'(s1_d[24] ? le_neg[k] : ge_pos[k]);
    end
    corr      = wrap_corr(qmag);
    step_wide = s1_d[24] ? d_ext + $signed(corr) : d_ext - $signed(corr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
      res_raw   <= '0;
      res_step  <= '0;
      res_total <= '0;
      res_err   <= '0;
    end else if (advance) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
      if (q_valid && q_data.ok) prev_pos <= q_data.pos;
      if (s2_valid) begin
        if (s2_ok) begin
          res_raw   <= s2_pos;
          res_step  <= s2_step;
          res_total <= res_total + {{7{s2_step[24]}}, s2_step};
        end else begin
          res_err <= res_err + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ok   <= q_data.ok;
      s1_pos  <= q_data.pos;
      s1_d    <= d_new;
      s2_ok   <= s1_ok;
      s2_pos  <= s1_pos;
      s2_step <= step_wide[24:0];
      res_ok  <= s2_ok;
    end
  end

endmodule

// ===== rtl/core/encoder_frame_position_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_frame_position_tracker: serial encoder frame to multi-turn position
// Hunts for the sync byte, assembles six-byte frames, checks their XOR byte
// and unwraps the 24-bit single-turn position into a 32-bit total.
// ----------------------------------------------------------------------------
//
//   channel   dir  transfer                 payload
//   --------  ---  -----------------------  -----------------------------------
//   byte_in   in   one serial byte          rx_byte
//   result    out  one completed frame      check_ok, raw_position,
//                                           position_step, total_position,
//                                           check_error_count
//   apb       in   register write or read   sync_byte at address 0
//
// One byte is taken every clock cycle while byte_in.ready is high. A result
// follows the transfer of the last byte of its frame through the queue and the
// registered stages for the difference, the wrap correction and the accumulation.
// Reset (rst, synchronous) returns to hunting with all counters at zero.
// A stalled result holds the back pipeline; the two-frame queue then fills and
// byte_in.ready drops only at the last byte of a frame that finds no room.
//
module encoder_frame_position_tracker (
  input  logic                            clk,
  input  logic                            rst,
  efpt_byte_if.sink                       byte_in,
  efpt_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [efpt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic                     [31:0] pwdata,
  output logic                     [31:0] prdata,
  output logic                            pready
);
  import efpt_pkg::*;

  logic [7:0]           sync_byte;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 push;
  frame_t               push_data;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  frame_t               q_data;

  // The register word index is the address above the byte offset.
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_SYNC_BYTE) ? {24'd0, sync_byte} : 32'd0;

  // The sync value only matters while hunting; a write in lock is kept, but
  // only reset ends the lock, and reset reloads the default value.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_SYNC_BYTE)) begin
      sync_byte <= pwdata[7:0];
    end
  end

  // Front: sync hunt, byte counting and the running XOR of the frame.
  efpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (sync_byte),
    .in_valid  (byte_in.valid),
    .in_byte   (byte_in.rx_byte),
    .in_ready  (byte_in.ready),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Queue of completed frame records between the two halves.
  efpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // Back: difference to the last good position, wrap correction, totals.
  // The result register holds the running state, so a failed frame shows the
  // last accepted position, step and total with the new error count.
  efpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_ok    (result.check_ok),
    .res_raw   (result.raw_position),
    .res_step  (result.position_step),
    .res_total (result.total_position),
    .res_err   (result.check_error_count)
  );

endmodule

// ===== rtl/core/efpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpt_checker: port-level checks of the encoder frame position tracker
// Watches the result channel and the running totals between transfers.
// ----------------------------------------------------------------------------
module efpt_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic               check_ok,
  input logic        [23:0] raw_position,
  input logic signed [24:0] position_step,
  input logic signed [31:0] total_position,
  input logic        [15:0] check_error_count
);

  logic [31:0] last_total;
  logic [15:0] last_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
      last_err   <= '0;
    end else if (res_valid && res_ready) begin
      last_total <= total_position;
      last_err   <= check_error_count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(check_ok) &&
      $stable(raw_position) && $stable(position_step) &&
      $stable(total_position) && $stable(check_error_count))
    else $error("stalled result changed");

  a_fail: assert property (@(posedge clk) disable iff (rst)
    res_valid && !check_ok |->
      check_error_count == last_err + 16'd1 && total_position == last_total)
    else $error("failed frame did not count exactly one error");

  a_good: assert property (@(posedge clk) disable iff (rst)
    res_valid && check_ok |->
      check_error_count == last_err &&
      total_position == last_total + {{7{position_step[24]}}, position_step})
    else $error("total does not follow the step");

  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result right after reset");

endmodule

bind encoder_frame_position_tracker efpt_checker u_efpt_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .check_ok          (result.check_ok),
  .raw_position      (result.raw_position),
  .position_step     (result.position_step),
  .total_position    (result.total_position),
  .check_error_count (result.check_error_count)
);

// ===== test/encoder_frame_position_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_frame_position_tracker_tb: self-checking bench of the frame tracker
// Streams serial encoder bytes into the tracker under random sender gaps and
// receiver stalls, predicts every frame result in the bench and compares each
// result transfer field by field. The sync register is written over APB.
// ----------------------------------------------------------------------------
module encoder_frame_position_tracker_tb;
  import efpt_pkg::*;

  // The run is bounded in two ways: the stimulus stops after the random byte
  // count, and a watchdog ends a hung run.
  localparam int RANDOM_BYTES  = 1550;
  localparam int PHASES        = 3;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RUN_LIMIT_NS  = 6_000_000;

  // One result of a completed frame, laid out like the result channel.
  typedef struct packed {
    logic               ok;
    logic        [23:0] raw;
    logic signed [24:0] step;
    logic signed [31:0] total;
    logic        [15:0] errs;
  } frame_result_t;

  // A row of the directed table: one byte, and on the last byte of some
  // frames a result written out by hand.
  typedef struct {
    logic [7:0]    rx;
    bit            typed;
    frame_result_t want;
  } directed_row_t;

  // Stall patterns of the result receiver.
  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_PERIODIC} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  efpt_byte_if   byte_ch ();
  efpt_result_if result_ch ();

  encoder_frame_position_tracker u_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench copy of the tracker state and of its sync register.
  logic [7:0]  cfg_sync;
  bit          trk_locked;
  int          trk_index;
  logic [7:0]  trk_frame [FRAME_BYTES];
  logic [23:0] trk_prev;
  logic [31:0] trk_acc;
  logic [15:0] trk_errs;
  logic [24:0] trk_step;

  frame_result_t  expected_frames [$];
  directed_row_t  directed_rows [$];
  int             fail_count;
  int             bytes_sent;
  int             burst_left;

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that has not ended by now is hung.
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic frame_result_t make_result(input logic ok, input logic [23:0] raw,
                                                input logic [24:0] step,
                                                input logic [31:0] total,
                                                input logic [15:0] errs);
    frame_result_t r;
    r.ok    = ok;
    r.raw   = raw;
    r.step  = step;
    r.total = total;
    r.errs  = errs;
    return r;
  endfunction

  // Predictor of one byte. While hunting, only the sync value gets in; once
  // locked, every sixth byte closes a frame, whatever its header is. A good
  // frame unwraps its position difference by whole multiples of the span
  // (truncating quotient by the half span), a bad one only bumps the count.
  task automatic predict_frame_byte(input logic [7:0] b, output bit done,
                                    output frame_result_t r);
    logic [7:0]  x;
    logic [23:0] pos;
    int          d;
    int          q;
    done = 1'b0;
    r    = '0;
    if (!trk_locked) begin
      if (b != cfg_sync) return;
      trk_locked = 1'b1;
      trk_index  = 0;
    end
    trk_frame[trk_index] = b;
    trk_index++;
    if (trk_index < FRAME_BYTES) return;
    trk_index = 0;
    x = trk_frame[0] ^ trk_frame[1] ^ trk_frame[2] ^ trk_frame[3] ^ trk_frame[4];
    if (x == trk_frame[IDX_CHECK]) begin
      pos = {trk_frame[IDX_POS2], trk_frame[IDX_POS1], trk_frame[IDX_POS0]};
      d = int'({8'h00, pos}) - int'({8'h00, trk_prev});
      q = d / WRAP_HALF;
      d = d - q * WRAP_SPAN;
      trk_prev = pos;
      trk_step = d[24:0];
      trk_acc  = trk_acc + 32'(d);
    end else begin
      trk_errs = trk_errs + 16'd1;
    end
    done = 1'b1;
    r = make_result(x == trk_frame[IDX_CHECK], trk_prev, trk_step, trk_acc, trk_errs);
  endtask

  // Sends one byte. The sender works in bursts; between bursts valid drops
  // for a random gap, which is skipped entirely when the gap comes out as
  // zero so that valid is never lowered and raised in one step. The byte is
  // predicted at the edge of its transfer; a hand-typed result, where the
  // row has one, stands in for the predicted one.
  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
    int            gap;
    bit            done;
    frame_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
    burst_left--;
    bytes_sent++;
    predict_frame_byte(b, done, r);
    if (done) expected_frames.push_back(typed ? want : r);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the data at
  // the edge that closes the access with pready high. The bus then goes idle.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // APB read, with the returned data compared against the bench copy.
  task automatic apb_check(input logic [REG_IDX_W-1:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata[7:0] !== want[7:0]) begin
      $error("sync_byte readback: expected %0d, actual %0d", want[7:0], prdata[7:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the sync register and reads it back.
  task automatic set_sync(input logic [7:0] value);
    apb_write(REG_SYNC_BYTE, {24'h0, value});
    cfg_sync = value;
    apb_check(REG_SYNC_BYTE, {24'h0, value});
  endtask

  // Brings the byte side to rest and waits out the last frame. A byte that
  // closes no frame may still sit in the pipeline, hence the extra cycles.
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] rx, input bit typed, input frame_result_t want);
    directed_row_t row;
    row.rx    = rx;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Directed table. The sync register holds 8'hFF here, so the reset sync
  // value and a zero byte are dropped during the hunt. Then a good frame at
  // position zero, a frame with a bad check byte (which leaves the position
  // fields alone and bumps the count), a jump to the top position (the
  // largest unwrap quotient) and a jump back down with the sync value in the
  // status byte, where it is plain data.
  task automatic load_directed();
    add_row(SYNC_RESET, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'hFF, 1'b1, make_result(1'b1, 24'h0, 25'sd0, 32'sd0, 16'd0));
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h12, 1'b0, '0);
    add_row(8'h34, 1'b0, '0);
    add_row(8'h56, 1'b0, '0);
    add_row(8'h00, 1'b1, make_result(1'b0, 24'h0, 25'sd0, 32'sd0, 16'd1));
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h00, 1'b1, make_result(1'b1, 24'hFFFFFF, -25'sd13942779,
                                     -32'sd13942779, 16'd1));
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
  endtask

  // Picks a new position relative to the last accepted one: anywhere, a small
  // move, a move of some multiple of the half span give or take a few counts
  // (to sit on the quotient boundaries), or a range end.
  function automatic logic [23:0] pick_position();
    int off;
    int k;
    case ($urandom_range(0, 4))
      0: return 24'($urandom);
      1: return trk_prev + 24'($signed($urandom_range(0, 2000)) - 1000);
      2, 3: begin
        k   = $urandom_range(1, 6);
        off = k * WRAP_HALF + $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 1) == 0 && int'({8'h00, trk_prev}) + off <= 24'hFFFFFF)
          return trk_prev + 24'(off);
        else if (int'({8'h00, trk_prev}) >= off)
          return trk_prev - 24'(off);
        else
          return 24'($urandom);
      end
      default: return ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
    endcase
  endfunction

  // One random frame. Most frames are well formed; some carry a broken check
  // byte, some a foreign header, and now and then a few stray bytes go ahead
  // of the frame to knock the alignment off.
  task automatic send_random_frame();
    logic [7:0]  fb [FRAME_BYTES];
    logic [23:0] pos;
    int          n;
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(8'($urandom), 1'b0, '0);
    end
    pos   = pick_position();
    fb[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : cfg_sync;
    fb[1] = 8'($urandom);
    fb[2] = pos[7:0];
    fb[3] = pos[15:8];
    fb[4] = pos[23:16];
    fb[5] = fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4];
    if ($urandom_range(0, 6) == 0) fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[i], 1'b0, '0);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result receiver. Its ready follows a pattern of its own, picked anew at
  // random intervals: always open, coin toss, mostly choked, or a fixed
  // one-in-four stall.
  initial begin
    stall_mode_t mode;
    int          left;
    int          tick;
    result_ch.ready <= 1'b0;
    left = 0;
    tick = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      tick++;
      case (mode)
        RX_OPEN:     result_ch.ready <= 1'b1;
        RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
        RX_CHOKE:    result_ch.ready <= ($urandom_range(0, 7) == 0);
        default:     result_ch.ready <= (tick % 4 != 0);
      endcase
    end
  end

  // Result monitor: every result transfer is matched against the oldest
  // pending frame. Values are read right at the edge, before any update.
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (expected_frames.size() == 0) begin
        $error("result transfer with no frame pending");
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        check_field("check_ok", want.ok, result_ch.check_ok);
        check_field("raw_position", want.raw, result_ch.raw_position);
        check_field("position_step", want.step, result_ch.position_step);
        check_field("total_position", want.total, result_ch.total_position);
        check_field("check_error_count", want.errs, result_ch.check_error_count);
      end
    end
  end

  // Main sequence.
  initial begin
    int target;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= 8'h00;
    fail_count = 0;
    bytes_sent = 0;
    burst_left = 0;
    cfg_sync   = SYNC_RESET;
    trk_locked = 1'b0;
    trk_index  = 0;
    for (int i = 0; i < FRAME_BYTES; i++) trk_frame[i] = 8'h00;
    trk_prev = '0;
    trk_acc  = '0;
    trk_errs = '0;
    trk_step = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The register must come out of reset at the default sync value; then
    // the top value goes in for the one and only hunt.
    apb_check(REG_SYNC_BYTE, {24'h0, SYNC_RESET});
    set_sync(8'hFF);

    load_directed();
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    wait_idle();

    // Random phases. The tracker stays locked, so later register values must
    // not disturb the stream; the low end, a random value and the reset value are written.
    bytes_sent = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_sync(8'h00);
        1:       set_sync(8'($urandom));
        default: set_sync(SYNC_RESET);
      endcase
      target = RANDOM_BYTES * (ph + 1) / PHASES;
      while (bytes_sent < target) send_random_frame();
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/efpt_pkg.sv
rtl/core/efpt_if.sv
rtl/core/efpt_front.sv
rtl/core/efpt_queue.sv
rtl/core/efpt_back.sv
rtl/core/encoder_frame_position_tracker.sv
rtl/core/efpt_checker.sv
test/encoder_frame_position_tracker_tb.sv
